/* hw/rtl/assert_macros.svh */
// Assertion helpers for the checker modules.
// Each macro expects a clock named clk in scope; AST_IMPL and AST_NEXT also expect an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`define AST_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

/* hw/rtl/pcsn_pkg.sv */
`default_nettype none
package pcsn_pkg;
  localparam int IN_W = 24;
  localparam int MW   = 2 * IN_W;
  localparam int SW   = 2 * MW;
  localparam int HW   = MW / 2;
  localparam int RW   = MW + 3;
  localparam int QW   = 15;
  localparam int OW   = 16;
  localparam int FRAC = 14;
  localparam logic [OW-1:0] ONE_Q = OW'(1 << FRAC);

  typedef struct packed {
    logic signed [IN_W-1:0] a_real;
    logic signed [IN_W-1:0] a_imag;
    logic signed [IN_W-1:0] b_real;
    logic signed [IN_W-1:0] b_imag;
    logic                   real_only;
  } in_item_t;

  typedef struct packed {
    logic signed [OW-1:0] out_real;
    logic signed [OW-1:0] out_imag;
  } out_item_t;

  typedef struct packed {
    logic [MW-1:0] pr_m;
    logic [MW-1:0] pi_m;
    logic          pr_neg;
    logic          pi_neg;
    logic          ro;
  } sq_side_t;

  typedef struct packed {
    logic          v;
    logic [SW-1:0] rad;
    logic [RW-1:0] rem;
    logic [MW-1:0] root;
    sq_side_t      side;
  } sq_bus_t;

  typedef struct packed {
    logic pr_neg;
    logic pi_neg;
    logic ro;
    logic zero;
  } dv_side_t;

  typedef struct packed {
    logic          v;
    logic [MW-1:0] d;
    logic [MW:0]   xr;
    logic [MW:0]   xi;
    logic [QW-1:0] qr;
    logic [QW-1:0] qi;
    dv_side_t      side;
  } dv_bus_t;
endpackage
`default_nettype wire

/* hw/rtl/pcsn_sqrt_cell.sv */
`default_nettype none
module pcsn_sqrt_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire pcsn_pkg::sq_bus_t d_in,
  output pcsn_pkg::sq_bus_t     d_out
);
  import pcsn_pkg::*;

  sq_bus_t       cell_r, cell_nxt;
  logic [RW-1:0] rem_sh, trial;
  logic          ge;

  always_comb begin
    rem_sh = {d_in.rem[RW-3:0], d_in.rad[SW-1:SW-2]};
    trial  = {{(RW-MW-2){1'b0}}, d_in.root, 2'b01};
    ge     = rem_sh >= trial;
    cell_nxt      = d_in;
    cell_nxt.rad  = {d_in.rad[SW-3:0], 2'b00};
    cell_nxt.rem  = ge ? rem_sh - trial : rem_sh;
    cell_nxt.root = {d_in.root[MW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.v <= 1'b0;
    end else if (en) begin
      cell_r.v <= cell_nxt.v;
    end
    if (en) begin
      cell_r.rad  <= cell_nxt.rad;
      cell_r.rem  <= cell_nxt.rem;
      cell_r.root <= cell_nxt.root;
      cell_r.side <= cell_nxt.side;
    end
  end

  assign d_out = cell_r;
endmodule
`default_nettype wire

/* hw/rtl/pcsn_div_cell.sv */
`default_nettype none
module pcsn_div_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire pcsn_pkg::dv_bus_t d_in,
  output pcsn_pkg::dv_bus_t     d_out
);
  import pcsn_pkg::*;

  dv_bus_t     cell_r, cell_nxt;
  logic [MW:0] dx, sr, si;
  logic        ger, gei;

  always_comb begin
    dx  = {1'b0, d_in.d};
    ger = d_in.xr >= dx;
    gei = d_in.xi >= dx;
    sr  = ger ? d_in.xr - dx : d_in.xr;
    si  = gei ? d_in.xi - dx : d_in.xi;
    cell_nxt    = d_in;
    cell_nxt.xr = {sr[MW-1:0], 1'b0};
    cell_nxt.xi = {si[MW-1:0], 1'b0};
    cell_nxt.qr = {d_in.qr[QW-2:0], ger};
    cell_nxt.qi = {d_in.qi[QW-2:0], gei};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.v <= 1'b0;
    end else if (en) begin
      cell_r.v <= cell_nxt.v;
    end
    if (en) begin
      cell_r.d    <= cell_nxt.d;
      cell_r.xr   <= cell_nxt.xr;
      cell_r.xi   <= cell_nxt.xi;
      cell_r.qr   <= cell_nxt.qr;
      cell_r.qi   <= cell_nxt.qi;
      cell_r.side <= cell_nxt.side;
    end
  end

  assign d_out = cell_r;
endmodule
`default_nettype wire

/* hw/rtl/phase_corr_spectrum_normalizer_unit.sv */
// Channel | Ports                           | Direction
// in      | in_valid, in_stall, in_data     | bins in
// out     | out_valid, out_stall, out_data  | unit phasors out
// One bin is taken per cycle while in_stall is low. Each result passes in order through
// five arithmetic stages, 48 square-root cells, 15 divider cells and the output register.
// Reset empties the pipeline; no clearing pass is needed.
// A stalled output result freezes the whole pipeline and raises in_stall.
`default_nettype none
module phase_corr_spectrum_normalizer_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pcsn_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pcsn_pkg::out_item_t      out_data
);
  import pcsn_pkg::*;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic ro1_r, ro2_r, ro3_r, ro4_r, ro5_r;
  logic signed [MW-1:0] arbr_r, aibi_r, aibr_r, arbi_r;
  logic signed [MW:0]   pr_s, pi_s, pr_abs, pi_abs;
  logic [MW-1:0] pr2_r, pi2_r, pr3_r, pi3_r, pr4_r, pi4_r, pr5_r, pi5_r;
  logic pn2_r, in2_r, pn3_r, in3_r, pn4_r, in4_r, pn5_r, in5_r;
  logic [MW-1:0] rhh_r, rhl_r, rll_r, ihh_r, ihl_r, ill_r;
  logic [SW-1:0] sqr_r, sqi_r, sum_r;
  sq_bus_t sq_bus [0:MW];
  dv_bus_t dv_bus [0:QW];
  out_item_t res_nxt, out_r;
  logic      out_v_r;
  logic [QW-1:0] qr_f, qi_f;

  assign adv      = !out_v_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r} <= '0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_comb begin
    pr_s   = (MW+1)'(arbr_r) + (MW+1)'(aibi_r);
    pi_s   = (MW+1)'(aibr_r) - (MW+1)'(arbi_r);
    pr_abs = pr_s[MW] ? -pr_s : pr_s;
    pi_abs = pi_s[MW] ? -pi_s : pi_s;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      arbr_r <= in_data.a_real * in_data.b_real;
      aibi_r <= in_data.a_imag * in_data.b_imag;
      aibr_r <= in_data.a_imag * in_data.b_real;
      arbi_r <= in_data.a_real * in_data.b_imag;
      ro1_r  <= in_data.real_only;

      pr2_r <= pr_abs[MW-1:0];
      pi2_r <= pi_abs[MW-1:0];
      pn2_r <= pr_s[MW];
      in2_r <= pi_s[MW];
      ro2_r <= ro1_r;

      rhh_r <= pr2_r[MW-1:HW] * pr2_r[MW-1:HW];
      rhl_r <= pr2_r[MW-1:HW] * pr2_r[HW-1:0];
      rll_r <= pr2_r[HW-1:0] * pr2_r[HW-1:0];
      ihh_r <= pi2_r[MW-1:HW] * pi2_r[MW-1:HW];
      ihl_r <= pi2_r[MW-1:HW] * pi2_r[HW-1:0];
      ill_r <= pi2_r[HW-1:0] * pi2_r[HW-1:0];
      {pr3_r, pi3_r, pn3_r, in3_r, ro3_r} <= {pr2_r, pi2_r, pn2_r, in2_r, ro2_r};

      sqr_r <= {rhh_r, {MW{1'b0}}} + (SW'(rhl_r) << (HW + 1)) + SW'(rll_r);
      sqi_r <= {ihh_r, {MW{1'b0}}} + (SW'(ihl_r) << (HW + 1)) + SW'(ill_r);
      {pr4_r, pi4_r, pn4_r, in4_r, ro4_r} <= {pr3_r, pi3_r, pn3_r, in3_r, ro3_r};

      sum_r <= sqr_r + sqi_r;
      {pr5_r, pi5_r, pn5_r, in5_r, ro5_r} <= {pr4_r, pi4_r, pn4_r, in4_r, ro4_r};
    end
  end

  always_comb begin
    sq_bus[0].v           = v5_r;
    sq_bus[0].rad         = sum_r;
    sq_bus[0].rem         = '0;
    sq_bus[0].root        = '0;
    sq_bus[0].side.pr_m   = pr5_r;
    sq_bus[0].side.pi_m   = pi5_r;
    sq_bus[0].side.pr_neg = pn5_r;
    sq_bus[0].side.pi_neg = in5_r;
    sq_bus[0].side.ro     = ro5_r;
  end

  for (genvar k = 0; k < MW; k++) begin : g_sqrt
    pcsn_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d_in  (sq_bus[k]),
      .d_out (sq_bus[k+1])
    );
  end

  always_comb begin
    dv_bus[0].v           = sq_bus[MW].v;
    dv_bus[0].d           = sq_bus[MW].root;
    dv_bus[0].xr          = {1'b0, sq_bus[MW].side.pr_m};
    dv_bus[0].xi          = {1'b0, sq_bus[MW].side.pi_m};
    dv_bus[0].qr          = '0;
    dv_bus[0].qi          = '0;
    dv_bus[0].side.pr_neg = sq_bus[MW].side.pr_neg;
    dv_bus[0].side.pi_neg = sq_bus[MW].side.pi_neg;
    dv_bus[0].side.ro     = sq_bus[MW].side.ro;
    dv_bus[0].side.zero   = sq_bus[MW].root == '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    pcsn_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d_in  (dv_bus[k]),
      .d_out (dv_bus[k+1])
    );
  end

  always_comb begin
    qr_f = dv_bus[QW].qr;
    qi_f = dv_bus[QW].qi;
    res_nxt.out_real = dv_bus[QW].side.pr_neg ? -OW'(qr_f) : OW'(qr_f);
    res_nxt.out_imag = dv_bus[QW].side.pi_neg ? -OW'(qi_f) : OW'(qi_f);
    if (dv_bus[QW].side.zero) begin
      res_nxt = '0;
    end
    if (dv_bus[QW].side.ro) begin
      res_nxt.out_real = ONE_Q;
      res_nxt.out_imag = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_bus[QW].v;
    end
    if (adv) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

/* hw/rtl/pcsn_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module pcsn_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire pcsn_pkg::out_item_t out_data
);
  import pcsn_pkg::*;

  logic signed [OW-1:0] one_s;
  assign one_s = ONE_Q;

  `AST_RST(a_rst_empty, !rst_n, !out_valid)
  `AST_IMPL(a_back_pressure, out_valid && out_stall, in_stall)
  `AST_IMPL(a_free_when_empty, !out_valid, !in_stall)
  `AST_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `AST_IMPL(a_range, out_valid, out_data.out_real <= one_s && out_data.out_real >= -one_s)
endmodule

bind phase_corr_spectrum_normalizer_unit pcsn_checker u_pcsn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
